[hdl/mmu_pkg.sv]
// Shared types and constants for the 4x4 fixed-point matrix multiply unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none

package mmu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int VALUE_W    = 32;
    localparam int DIM        = 4;
    localparam int DIM_W      = 2;
    localparam int NUM_ELEMS  = DIM * DIM;
    localparam int POS_W      = 2 * DIM_W;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + DIM_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_ELEMS - 1);

    typedef struct packed {
        logic signed [31:0] a_element;
        logic signed [31:0] b_element;
    } mmu_request_t;

    typedef struct packed {
        logic signed [31:0] product_value;
        logic [3:0]         product_index;
        logic               last_result;
    } mmu_result_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        logic [POS_W-1:0]      pos;
        logic                  last;
    } mmu_load_t;

endpackage

`default_nettype wire

[hdl/mmu_front.sv]
// Front end: accepts requests, tags each with its row-major position and
// the end-of-matrix mark, and pushes it into the load queue. Uses mmu_pkg.
`default_nettype none

module mmu_front
    import mmu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  mmu_request_t req,
    output logic         req_stall,
    input  logic         q_full,
    output logic         push_valid,
    output mmu_load_t    push_entry
);

    logic [POS_W-1:0] load_count_reg;
    logic [POS_W-1:0] load_count_next;
    logic             accept;

    assign req_stall  = q_full;
    assign push_valid = req_valid;
    assign accept     = req_valid && !q_full;

    always_comb
    begin
        push_entry.a    = req.a_element[DATA_WIDTH-1:0];
        push_entry.b    = req.b_element[DATA_WIDTH-1:0];
        push_entry.pos  = load_count_reg;
        push_entry.last = (load_count_reg == LAST_POS);
        load_count_next = load_count_reg;
        if (accept)
        begin
            load_count_next = load_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/mmu_queue.sv]
// Two-entry queue that decouples the front end from the compute back end.
// Uses mmu_pkg for the entry type.
`default_nettype none

module mmu_queue
    import mmu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    input  mmu_load_t push_entry,
    output logic      full,
    input  logic      pop,
    output logic      valid,
    output mmu_load_t entry
);

    mmu_load_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign push  = push_valid && !full;
    assign entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[hdl/mmu_back.sv]
// Back end: stores the matrices in per-column and per-row banks and computes
// one product element per cycle while the output is not stalled, through read,
// multiply, sum and saturate stages. Uses mmu_pkg.
`default_nettype none

module mmu_back
    import mmu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  mmu_load_t   q_entry,
    output logic        q_pop,
    output logic        res_valid,
    input  logic        res_stall,
    output mmu_result_t res
);

    // Bank k of A holds column k (indexed by row); bank k of B holds row k.
    logic [DATA_WIDTH-1:0]    a_bank_reg [DIM][DIM];
    logic [DATA_WIDTH-1:0]    b_bank_reg [DIM][DIM];

    logic                     busy_reg;
    logic                     busy_next;
    logic [POS_W-1:0]         issue_idx_reg;
    logic [POS_W-1:0]         issue_idx_next;
    logic                     adv;

    logic                     rd_valid_reg;
    logic [POS_W-1:0]         rd_idx_reg;
    logic signed [DATA_WIDTH-1:0] a_rd_reg [DIM];
    logic signed [DATA_WIDTH-1:0] b_rd_reg [DIM];

    logic                     mul_valid_reg;
    logic [POS_W-1:0]         mul_idx_reg;
    logic signed [PROD_W-1:0] prod_next [DIM];
    logic signed [PROD_W-1:0] prod_reg [DIM];

    logic                     sum_valid_reg;
    logic [POS_W-1:0]         sum_idx_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SUM_W-1:0]  sum_reg;

    logic signed [SUM_W-1:0]  shifted;
    logic [SUM_W-DATA_WIDTH:0] upper;
    logic [DATA_WIDTH-1:0]    sat_value;

    logic                     res_valid_reg;
    mmu_result_t              res_reg;

    assign adv   = !res_valid_reg || !res_stall;
    assign q_pop = q_valid && !busy_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        issue_idx_next = issue_idx_reg;
        if (busy_reg && adv)
        begin
            issue_idx_next = issue_idx_reg + 1'b1;
            if (issue_idx_reg == LAST_POS)
            begin
                busy_next = 1'b0;
            end
        end
        else if (q_pop && q_entry.last)
        begin
            busy_next      = 1'b1;
            issue_idx_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                if (q_entry.pos[DIM_W-1:0] == DIM_W'(k))
                begin
                    a_bank_reg[k][q_entry.pos[POS_W-1:DIM_W]] <= q_entry.a;
                end
                if (q_entry.pos[POS_W-1:DIM_W] == DIM_W'(k))
                begin
                    b_bank_reg[k][q_entry.pos[DIM_W-1:0]] <= q_entry.b;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && adv)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                a_rd_reg[k] <= a_bank_reg[k][issue_idx_reg[POS_W-1:DIM_W]];
                b_rd_reg[k] <= b_bank_reg[k][issue_idx_reg[DIM_W-1:0]];
            end
            rd_idx_reg <= issue_idx_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < DIM; k++)
        begin
            prod_next[k] = a_rd_reg[k] * b_rd_reg[k];
        end
        sum_next = prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];
    end

    always_comb
    begin
        shifted = sum_reg >>> FRAC_BITS;
        upper   = shifted[SUM_W-1:DATA_WIDTH-1];
        if ((&upper) || !(|upper))
        begin
            sat_value = shifted[DATA_WIDTH-1:0];
        end
        else if (shifted[SUM_W-1])
        begin
            sat_value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIM; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            mul_idx_reg               <= rd_idx_reg;
            sum_reg                   <= sum_next;
            sum_idx_reg               <= mul_idx_reg;
            res_reg.product_value     <= VALUE_W'(sat_value);
            res_reg.product_index     <= sum_idx_reg;
            res_reg.last_result       <= (sum_idx_reg == LAST_POS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issue_idx_reg <= issue_idx_next;
            if (adv)
            begin
                rd_valid_reg  <= busy_reg;
                mul_valid_reg <= rd_valid_reg;
                sum_valid_reg <= mul_valid_reg;
                res_valid_reg <= sum_valid_reg;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[hdl/matrix_multiply_4x4_unit.sv]
// 4x4 signed Q16.16 matrix multiply: sixteen requests load A and B, then
// sixteen product elements stream out in row-major order, one per cycle when not
// stalled. The first element follows the sixteenth request through the load queue
// and the read, multiply, sum and saturate stages. Requests are taken one per cycle
// while the two-entry load queue has room; the single compute pipeline holds the
// banks while issuing. Reset clears the load position and pipeline, not the banks.
`default_nettype none

module matrix_multiply_4x4_unit
    import mmu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    input  mmu_request_t req,
    output logic         req_stall,
    output logic         res_valid,
    input  logic         res_stall,
    output mmu_result_t  res
);

    logic      q_full;
    logic      push_valid;
    mmu_load_t push_entry;
    logic      q_valid;
    mmu_load_t q_entry;
    logic      q_pop;

    mmu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req        (req),
        .req_stall  (req_stall),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    mmu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .entry      (q_entry)
    );

    mmu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // The end mark appears exactly on the last element of a product.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.last_result == (res.product_index == LAST_POS)))
    else $error("last_result does not match the final element index");

    // Within one product, elements leave in consecutive row-major order.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && !res.last_result) |=>
        (!res_valid || (res.product_index == $past(res.product_index) + 4'd1)))
    else $error("product elements left out of order");

    // A request that ends a matrix pair only leaves the queue when compute is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_entry.last) |=> !q_pop)
    else $error("load popped while the banks were being read");

endmodule

`default_nettype wire

[verif/matrix_multiply_4x4_unit_test.sv]
// Self-checking testbench for the 4x4 signed Q16.16 matrix multiply unit.
// Streams matrix pairs through the request channel and checks every element against a
// corner table or a local predictor; depends on mmu_pkg and matrix_multiply_4x4_unit.
module matrix_multiply_4x4_unit_test
    import mmu_pkg::*;
;

    localparam int IDLE_LIMIT      = 2000;
    localparam int RANDOM_MATRICES = 17;

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_NEG = 32'hffff_ffff;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] product;
    } corner_row_t;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         req_valid = 1'b0;
    mmu_request_t req       = '0;
    logic         req_stall;
    logic         res_valid;
    logic         res_stall = 1'b0;
    mmu_result_t  res;

    logic signed [31:0] left_store [NUM_ELEMS];
    logic signed [31:0] right_store [NUM_ELEMS];
    logic [POS_W-1:0]   load_pos = '0;
    mmu_result_t        pending_products [$];

    int error_count   = 0;
    int idle_cycles   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // A rows: all largest, all smallest, all one LSB, unit at column three.
    // B columns: largest, smallest, minus one LSB, unit column.
    corner_row_t corner_rows [NUM_ELEMS] = '{
        '{Q_MAX, Q_MAX, Q_MAX},         '{Q_MAX, Q_MIN, Q_MIN},
        '{Q_MAX, Q_NEG, 32'hfffe_0000}, '{Q_MAX, 32'h0, Q_MAX},
        '{Q_MIN, Q_MAX, Q_MIN},         '{Q_MIN, Q_MIN, Q_MAX},
        '{Q_MIN, Q_NEG, 32'h0002_0000}, '{Q_MIN, 32'h0, Q_MIN},
        '{32'h1, Q_MAX, 32'h0001_ffff}, '{32'h1, Q_MIN, 32'hfffe_0000},
        '{32'h1, Q_NEG, Q_NEG},         '{32'h1, 32'h0, 32'h1},
        '{32'h0, Q_MAX, Q_MAX},         '{32'h0, Q_MIN, Q_MIN},
        '{32'h0, Q_NEG, Q_NEG},         '{Q_ONE, Q_ONE, Q_ONE}
    };

    matrix_multiply_4x4_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] product_element(int row, int col);
        logic signed [65:0] acc;
        logic signed [65:0] av;
        logic signed [65:0] bv;
        acc = '0;
        for (int k = 0; k < DIM; k++)
        begin
            av  = left_store[row * DIM + k];
            bv  = right_store[k * DIM + col];
            acc = acc + av * bv;
        end
        acc = acc >>> FRAC_BITS;
        if (acc > SAT_HI)
            return Q_MAX;
        if (acc < SAT_LO)
            return Q_MIN;
        return acc[31:0];
    endfunction

    function automatic void store_request(mmu_request_t r, bit from_table);
        mmu_result_t e;
        left_store[load_pos]  = r.a_element;
        right_store[load_pos] = r.b_element;
        if (load_pos == LAST_POS)
        begin
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                e.product_value = from_table ? corner_rows[i].product
                                             : product_element(i / DIM, i % DIM);
                e.product_index = POS_W'(i);
                e.last_result   = (i == NUM_ELEMS - 1);
                pending_products.push_back(e);
            end
        end
        load_pos = load_pos + 1'b1;
    endfunction

    function automatic logic [31:0] random_element(int style);
        case (style)
            0: return $urandom;
            1: return $urandom_range(1 << 20) - (1 << 19);
            default:
                case ($urandom_range(5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_NEG;
                    4: return Q_ONE;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    task automatic send_request(mmu_request_t r, bit from_table);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        store_request(r, from_table);
    endtask

    always @(posedge clk)
        res_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : check_results
        mmu_result_t e;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_products.size() == 0)
            begin
                $error("product_value: expected none, got %h at index %0d",
                       res.product_value, res.product_index);
                error_count++;
            end
            else
            begin
                e = pending_products.pop_front();
                if (res.product_value !== e.product_value)
                begin
                    $error("product_value: expected %h, got %h",
                           e.product_value, res.product_value);
                    error_count++;
                end
                if (res.product_index !== e.product_index)
                begin
                    $error("product_index: expected %0d, got %0d",
                           e.product_index, res.product_index);
                    error_count++;
                end
                if (res.last_result !== e.last_result)
                begin
                    $error("last_result: expected %b, got %b",
                           e.last_result, res.last_result);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        mmu_request_t r;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ELEMS; i++)
        begin
            r.a_element = corner_rows[i].a;
            r.b_element = corner_rows[i].b;
            send_request(r, 1'b1);
        end

        for (int m = 0; m < RANDOM_MATRICES; m++)
        begin
            int style;
            if (m == 8 || m == 12)
            begin
                req_valid <= 1'b0;
                while (pending_products.size() != 0)
                    @(posedge clk);
            end
            if (m < 4)
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            else if (m < 8)
            begin
                send_idle_pct = 70;
                stall_pct     = 0;
            end
            else if (m < 12)
            begin
                send_idle_pct = 0;
                stall_pct     = 70;
            end
            else
            begin
                send_idle_pct = 36;
                stall_pct     = 36;
            end
            style = $urandom_range(2);
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                r.a_element = random_element(style);
                r.b_element = random_element(style);
                send_request(r, 1'b0);
            end
        end
        req_valid <= 1'b0;

        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[matrix_multiply_4x4_unit.f]
hdl/mmu_pkg.sv
hdl/mmu_front.sv
hdl/mmu_queue.sv
hdl/mmu_back.sv
hdl/matrix_multiply_4x4_unit.sv
verif/matrix_multiply_4x4_unit_test.sv
